>>> hdl/sspq_pkg.sv
// Shared types, sizes, glyph table and pixel function of the seven-segment pixel query.
`default_nettype none

package sspq_pkg;

  localparam int MAX_DIGITS = 256;
  localparam int MAX_SCALE  = 63;

  localparam int ADDR_W  = $clog2(MAX_DIGITS);
  localparam int COUNT_W = $clog2(MAX_DIGITS + 1);
  localparam int DIGIT_W = 4;
  localparam int SCALE_W = 6;
  localparam int COL_W   = 16;
  localparam int ROW_W   = 8;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PX_BLANK = 2'd0,
    PX_UNDER = 2'd1,
    PX_BAR   = 2'd2
  } pix_t;

  // One stored digit: its value, its scale and its rightmost column.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [SCALE_W-1:0] scale;
    logic [COL_W-1:0]   end_col;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam int GLYPH_DIGITS = 10;
  localparam int GLYPH_CELLS  = 9;

  // Per digit: top line (left, mid, right), middle line, bottom line.
  localparam pix_t GLYPH_TABLE [GLYPH_DIGITS][GLYPH_CELLS] = '{
    '{PX_BLANK, PX_UNDER, PX_BLANK, PX_BAR,   PX_BLANK, PX_BAR,
      PX_BAR,   PX_UNDER, PX_BAR},
    '{PX_BLANK, PX_BLANK, PX_BLANK, PX_BLANK, PX_BLANK, PX_BAR,
      PX_BLANK, PX_BLANK, PX_BAR},
    '{PX_BLANK, PX_UNDER, PX_BLANK, PX_BLANK, PX_UNDER, PX_BAR,
      PX_BAR,   PX_UNDER, PX_BLANK},
    '{PX_BLANK, PX_UNDER, PX_BLANK, PX_BLANK, PX_UNDER, PX_BAR,
      PX_BLANK, PX_UNDER, PX_BAR},
    '{PX_BLANK, PX_BLANK, PX_BLANK, PX_BAR,   PX_UNDER, PX_BAR,
      PX_BLANK, PX_BLANK, PX_BAR},
    '{PX_BLANK, PX_UNDER, PX_BLANK, PX_BAR,   PX_UNDER, PX_BLANK,
      PX_BLANK, PX_UNDER, PX_BAR},
    '{PX_BLANK, PX_UNDER, PX_BLANK, PX_BAR,   PX_UNDER, PX_BLANK,
      PX_BAR,   PX_UNDER, PX_BAR},
    '{PX_BLANK, PX_UNDER, PX_BLANK, PX_BLANK, PX_BLANK, PX_BAR,
      PX_BLANK, PX_BLANK, PX_BAR},
    '{PX_BLANK, PX_UNDER, PX_BLANK, PX_BAR,   PX_UNDER, PX_BAR,
      PX_BAR,   PX_UNDER, PX_BAR},
    '{PX_BLANK, PX_UNDER, PX_BLANK, PX_BAR,   PX_UNDER, PX_BAR,
      PX_BLANK, PX_UNDER, PX_BAR}
  };

  localparam logic [3:0] LINE_TOP    = 4'd0;
  localparam logic [3:0] LINE_MIDDLE = 4'd3;
  localparam logic [3:0] LINE_BOTTOM = 4'd6;

  // Pixel of one glyph; dx is 0 at the rightmost column and scale+1 at the leftmost.
  function automatic pix_t glyph_pixel(logic [COL_W-1:0]   dx,
                                       logic [ROW_W-1:0]   row,
                                       logic [DIGIT_W-1:0] dig,
                                       logic [SCALE_W-1:0] scale);
    logic [ROW_W-1:0] f;
    logic [ROW_W-1:0] two_f;
    logic [COL_W-1:0] left_dx;
    logic [3:0]       line;
    logic             strokes_only;
    pix_t             px;
    f       = ROW_W'(scale);
    two_f   = ROW_W'({scale, 1'b0});
    left_dx = COL_W'(scale) + COL_W'(1);
    if (row == '0) begin
      line = LINE_BOTTOM;
      strokes_only = 1'b0;
    end else if (row < f) begin
      line = LINE_BOTTOM;
      strokes_only = 1'b1;
    end else if (row == f) begin
      line = LINE_MIDDLE;
      strokes_only = 1'b0;
    end else if (row < two_f) begin
      line = LINE_MIDDLE;
      strokes_only = 1'b1;
    end else begin
      line = LINE_TOP;
      strokes_only = 1'b0;
    end
    px = PX_BLANK;
    if (dig < DIGIT_W'(GLYPH_DIGITS) && row <= two_f) begin
      if (dx == left_dx) begin
        px = GLYPH_TABLE[dig][line];
      end else if (dx == '0) begin
        px = GLYPH_TABLE[dig][line + 4'd2];
      end else if (!strokes_only) begin
        px = GLYPH_TABLE[dig][line + 4'd1];
      end
    end
    return px;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sspq_if.sv
// Handshake channels for commands into and pixel results out of the query block.
`default_nettype none

interface sspq_cmd_if
  import sspq_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [DIGIT_W-1:0] digit_value;
  logic [SCALE_W-1:0] digit_scale;
  logic [COL_W-1:0]   query_column;
  logic [ROW_W-1:0]   query_row;

  modport source (output valid, cmd, digit_value, digit_scale, query_column, query_row,
                  input ready);
  modport sink   (input valid, cmd, digit_value, digit_scale, query_column, query_row,
                  output ready);
endinterface

interface sspq_pix_if;
  logic       valid;
  logic       ready;
  logic [1:0] pixel_code;
  logic       past_end;

  modport source (output valid, pixel_code, past_end, input ready);
  modport sink   (input valid, pixel_code, past_end, output ready);
endinterface

`default_nettype wire

>>> hdl/sspq_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module sspq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hdl/scaled_seven_segment_pixel_query.sv
// Clear and append are taken in the idle state; a query runs a binary search over the n stored
// digits that spends a read state and a compare state per step on the entry RAM port.
// One item is worked at a time; a finished pixel waits in the output register while the next
// command is taken. Synchronous reset empties the row and drops any pending result; the entry
// RAM is not cleared, since only entries below the digit count are ever used.
`default_nettype none

module scaled_seven_segment_pixel_query
  import sspq_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  sspq_cmd_if.sink  cmd_chan,
  sspq_pix_if.source pixel_chan
);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_SEARCH_RD  = 6'b000010,
    S_SEARCH_CMP = 6'b000100,
    S_FETCH_PREV = 6'b001000,
    S_EVAL       = 6'b010000,
    S_DELIVER    = 6'b100000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [COUNT_W-1:0] count;
  logic [COL_W-1:0]   last_end;
  logic [COUNT_W-1:0] lo;
  logic [COUNT_W-1:0] hi;
  logic [ADDR_W-1:0]  mid;
  logic [COL_W-1:0]   q_col;
  logic [ROW_W-1:0]   q_row;
  entry_t             cur;
  pix_t               res_code;
  logic               res_past;
  logic               out_valid;
  pix_t               out_code;
  logic               out_past;

  logic               accept;
  logic               do_append;
  logic [SCALE_W-1:0] sat_scale;
  logic [COL_W-1:0]   new_end;
  logic [COUNT_W-1:0] mid_calc;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;
  logic               gap;
  logic               out_free;

  assign accept    = cmd_chan.valid && cmd_chan.ready;
  assign do_append = accept && cmd_chan.cmd == CMD_APPEND && count < COUNT_W'(MAX_DIGITS);
  assign sat_scale = (cmd_chan.digit_scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE)
                                                                 : cmd_chan.digit_scale;
  assign new_end   = (count == '0) ? COL_W'(sat_scale) + COL_W'(1)
                                   : last_end + COL_W'(sat_scale) + COL_W'(3);
  assign mid_calc  = lo + ((hi - lo) >> 1);
  assign ram_rdata = entry_t'(ram_rbits);
  assign gap       = lo != '0 && COL_W'(ram_rdata.end_col + COL_W'(1)) == q_col;
  assign out_free  = !out_valid || pixel_chan.ready;

  assign ram_we    = do_append;
  assign ram_wdata = '{digit: cmd_chan.digit_value, scale: sat_scale, end_col: new_end};

  always_comb begin
    unique case (state)
      S_IDLE:       ram_addr = count[ADDR_W-1:0];
      S_SEARCH_RD:  ram_addr = mid_calc[ADDR_W-1:0];
      S_FETCH_PREV: ram_addr = ADDR_W'(lo - COUNT_W'(1));
      default:      ram_addr = lo[ADDR_W-1:0];
    endcase
  end

  sspq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_DIGITS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rbits)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd_chan.cmd == CMD_QUERY) begin
          state_next = S_SEARCH_RD;
        end
      end
      S_SEARCH_RD: begin
        if (lo < hi) begin
          state_next = S_SEARCH_CMP;
        end else if (lo == count) begin
          state_next = S_DELIVER;
        end else begin
          state_next = S_FETCH_PREV;
        end
      end
      S_SEARCH_CMP: state_next = S_SEARCH_RD;
      S_FETCH_PREV: state_next = S_EVAL;
      S_EVAL:       state_next = S_DELIVER;
      S_DELIVER: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && cmd_chan.cmd == CMD_CLEAR) begin
        count <= '0;
      end else if (do_append) begin
        count <= count + COUNT_W'(1);
      end
      if (state == S_DELIVER && out_free) begin
        out_valid <= 1'b1;
      end else if (pixel_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      last_end <= new_end;
    end
    if (accept) begin
      q_col <= cmd_chan.query_column;
      q_row <= cmd_chan.query_row;
      lo    <= '0;
      hi    <= count;
    end
    unique case (state)
      S_SEARCH_RD: begin
        mid <= mid_calc[ADDR_W-1:0];
        // Preset for a search that ends beyond the last digit; S_EVAL overwrites it otherwise.
        res_code <= PX_BLANK;
        res_past <= 1'b1;
      end
      S_SEARCH_CMP: begin
        if (ram_rdata.end_col < q_col) begin
          lo <= COUNT_W'(mid) + COUNT_W'(1);
        end else begin
          hi <= COUNT_W'(mid);
        end
      end
      S_FETCH_PREV: cur <= ram_rdata;
      S_EVAL: begin
        res_past <= 1'b0;
        // The entry read now is the digit to the left; its end plus one is the gap column.
        if (gap) begin
          res_code <= PX_BLANK;
        end else begin
          res_code <= glyph_pixel(cur.end_col - q_col, q_row, cur.digit, cur.scale);
        end
      end
      default: ;
    endcase
    if (state == S_DELIVER && out_free) begin
      out_code <= res_code;
      out_past <= res_past;
    end
  end

  assign cmd_chan.ready        = state == S_IDLE;
  assign pixel_chan.valid      = out_valid;
  assign pixel_chan.pixel_code = out_code;
  assign pixel_chan.past_end   = out_past;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_DIGITS))
    else $error("digit count exceeds the row capacity");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH_RD |-> lo <= hi && hi <= count)
    else $error("binary search window left the stored digits");

  a_past_blank: assert property (@(posedge clk) disable iff (rst)
    pixel_chan.valid && pixel_chan.past_end |-> pixel_chan.pixel_code == PX_BLANK)
    else $error("pixel beyond the last digit is not blank");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_chan.cmd == CMD_QUERY |=> !cmd_chan.ready && $stable(count))
    else $error("command taken or row changed while a query is in flight");

endmodule

`default_nettype wire

>>> tb/tb_scaled_seven_segment_pixel_query.sv
// Self-checking testbench for the seven-segment pixel query block: command stream in, pixels checked.
module tb_scaled_seven_segment_pixel_query;
  import sspq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET  = 1000;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS  = 10;

  localparam int TOP_LINE    = 0;
  localparam int MIDDLE_LINE = 3;
  localparam int BOTTOM_LINE = 6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [DIGIT_W-1:0] digit_value;
    logic [SCALE_W-1:0] digit_scale;
    logic [COL_W-1:0]   query_column;
    logic [ROW_W-1:0]   query_row;
  } command_t;

  typedef struct packed {
    pix_t pixel_code;
    logic past_end;
  } pixel_result_t;

  class pixel_scoreboard;
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    logic [SCALE_W-1:0] scales [MAX_DIGITS];
    logic [COL_W-1:0]   end_cols [MAX_DIGITS];
    int unsigned        count;
    pixel_result_t      expected_pixels [$];
    int unsigned        appends, refused, clears, queries, past_ends, ignored;
    int unsigned        checked, errors;

    // Each art string holds the top, middle and bottom lines, three cells each.
    function string glyph_art(int unsigned d);
      case (d)
        0: return "._.|.||_|";
        1: return ".....|..|";
        2: return "._.._||_.";
        3: return "._.._|._|";
        4: return "...|_|..|";
        5: return "._.|_.._|";
        6: return "._.|_.|_|";
        7: return "._...|..|";
        8: return "._.|_||_|";
        9: return "._.|_|._|";
        default: return ".........";
      endcase
    endfunction

    function pix_t art_to_pix(byte ch);
      case (ch)
        "_": return PX_UNDER;
        "|": return PX_BAR;
        default: return PX_BLANK;
      endcase
    endfunction

    // dx counts from the rightmost column of the digit.
    function pix_t segment_pixel(int unsigned dx, int unsigned row, int unsigned dig,
                                 int unsigned f);
      string       art;
      int unsigned line;
      bit          strokes_only;
      art = glyph_art(dig);
      if (row > 2 * f) return PX_BLANK;
      if (row == 0) begin
        line = BOTTOM_LINE;
        strokes_only = 1'b0;
      end else if (row < f) begin
        line = BOTTOM_LINE;
        strokes_only = 1'b1;
      end else if (row == f) begin
        line = MIDDLE_LINE;
        strokes_only = 1'b0;
      end else if (row < 2 * f) begin
        line = MIDDLE_LINE;
        strokes_only = 1'b1;
      end else begin
        line = TOP_LINE;
        strokes_only = 1'b0;
      end
      if (dx == f + 1) return art_to_pix(art[line]);
      if (dx == 0) return art_to_pix(art[line + 2]);
      if (strokes_only) return PX_BLANK;
      return art_to_pix(art[line + 1]);
    endfunction

    function pixel_result_t predict_pixel(int unsigned col, int unsigned row);
      pixel_result_t r;
      int unsigned   idx;
      idx = 0;
      // End columns rise strictly, so the first one at or right of col owns it.
      while (idx < count && end_cols[idx] < col) idx++;
      r.pixel_code = PX_BLANK;
      r.past_end   = 1'b0;
      if (idx >= count) begin
        r.past_end = 1'b1;
      end else if (!(idx > 0 && end_cols[idx - 1] + 1 == col)) begin
        r.pixel_code = segment_pixel(end_cols[idx] - col, row, digits[idx], scales[idx]);
      end
      return r;
    endfunction

    function void note_error(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
    endfunction

    function void note_command(command_t c);
      int unsigned   s;
      pixel_result_t r;
      case (c.cmd)
        CMD_CLEAR: begin
          count = 0;
          clears++;
        end
        CMD_APPEND: begin
          if (count == MAX_DIGITS) begin
            refused++;
          end else begin
            s = c.digit_scale;
            if (s > MAX_SCALE) s = MAX_SCALE;
            digits[count] = c.digit_value;
            scales[count] = SCALE_W'(s);
            end_cols[count] = (count == 0) ? COL_W'(s + 1) : COL_W'(end_cols[count - 1] + s + 3);
            count++;
            appends++;
          end
        end
        CMD_QUERY: begin
          r = predict_pixel(c.query_column, c.query_row);
          expected_pixels.push_back(r);
          queries++;
          if (r.past_end) past_ends++;
        end
        default: ignored++;
      endcase
    endfunction

    function void check_pixel(logic [1:0] code, logic past);
      pixel_result_t want;
      checked++;
      if (expected_pixels.size() == 0) begin
        note_error($sformatf("pixel %0d past_end %0d arrived with no query waiting", code, past));
        return;
      end
      want = expected_pixels.pop_front();
      if (code !== want.pixel_code || past !== want.past_end)
        note_error($sformatf("pixel %0d past_end %0d, expected pixel %0d past_end %0d",
                             code, past, want.pixel_code, want.past_end));
    endfunction

    function void close_out();
      if (expected_pixels.size() != 0)
        note_error($sformatf("%0d expected pixels never arrived", expected_pixels.size()));
    endfunction
  endclass

  logic clk;
  logic rst;

  sspq_cmd_if cmd_chan ();
  sspq_pix_if pixel_chan ();

  scaled_seven_segment_pixel_query dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_chan   (cmd_chan),
    .pixel_chan (pixel_chan)
  );

  pixel_scoreboard sb;
  int unsigned     burst_left;
  int unsigned     idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic command_t random_fields(logic [1:0] op);
    command_t c;
    c.cmd          = op;
    c.digit_value  = DIGIT_W'($urandom);
    c.digit_scale  = SCALE_W'($urandom);
    c.query_column = COL_W'($urandom);
    c.query_row    = ROW_W'($urandom);
    return c;
  endfunction

  // Sends one command in the current burst; a new burst may start after a gap.
  task automatic send_command(command_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        cmd_chan.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    cmd_chan.valid        <= 1'b1;
    cmd_chan.cmd          <= c.cmd;
    cmd_chan.digit_value  <= c.digit_value;
    cmd_chan.digit_scale  <= c.digit_scale;
    cmd_chan.query_column <= c.query_column;
    cmd_chan.query_row    <= c.query_row;
    do @(posedge clk); while (!cmd_chan.ready);
    sb.note_command(c);
  endtask

  task automatic clear_row();
    send_command(random_fields(CMD_CLEAR));
  endtask

  task automatic append_digit(int unsigned v, int unsigned s);
    command_t c;
    c = random_fields(CMD_APPEND);
    c.digit_value = DIGIT_W'(v);
    c.digit_scale = SCALE_W'(s);
    send_command(c);
  endtask

  task automatic query_pixel(int unsigned col, int unsigned row);
    command_t c;
    c = random_fields(CMD_QUERY);
    c.query_column = COL_W'(col);
    c.query_row    = ROW_W'(row);
    send_command(c);
  endtask

  function automatic int unsigned random_digit();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
  endfunction

  function automatic int unsigned random_scale();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return MAX_SCALE;
      2, 3: return $urandom_range(0, MAX_SCALE);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // Mostly aims at a stored digit, its edges, the gaps around it and its stroke rows.
  task automatic random_query();
    int unsigned idx, f, left, col, row;
    if (sb.count == 0 || $urandom_range(0, 9) == 0) begin
      query_pixel($urandom_range(0, 65535), $urandom_range(0, 255));
      return;
    end
    idx  = $urandom_range(0, sb.count - 1);
    f    = sb.scales[idx];
    left = sb.end_cols[idx] - f - 1;
    col  = left + $urandom_range(0, f + 2);
    if (left > 0 && $urandom_range(0, 7) == 0) col = left - 1;
    case ($urandom_range(0, 5))
      0: row = 0;
      1: row = f;
      2: row = 2 * f;
      3: row = 2 * f + 1;
      default: row = $urandom_range(0, 2 * f);
    endcase
    query_pixel(col, row);
  endtask

  task automatic build_row(bit fill);
    int unsigned n;
    n = fill ? MAX_DIGITS + $urandom_range(1, 3) : $urandom_range(1, 12);
    if (fill || $urandom_range(0, 3) != 0) clear_row();
    repeat (n) append_digit(random_digit(), random_scale());
  endtask

  task automatic run_directed();
    query_pixel(0, 0);
    send_command(random_fields(CMD_UNUSED));
    append_digit(8, 1);
    append_digit(0, MAX_SCALE);
    append_digit(15, 0);
    append_digit(9, 0);
    query_pixel(0, 0);
    query_pixel(1, 2);
    query_pixel(1, 1);
    query_pixel(3, 0);
    query_pixel(4, MAX_SCALE);
    query_pixel(68, 2 * MAX_SCALE);
    query_pixel(5, 2 * MAX_SCALE);
    query_pixel(4, 2 * MAX_SCALE + 1);
    query_pixel(70, 0);
    query_pixel(74, 0);
    query_pixel(73, 255);
    query_pixel(75, 0);
    query_pixel(65535, 255);
    append_digit(2, MAX_SCALE);
    query_pixel(140, 0);
    clear_row();
    query_pixel(0, 0);
    append_digit(7, 5);
    query_pixel(0, 10);
  endtask

  task automatic run_random();
    int unsigned phase;
    phase = 0;
    while (sb.appends + sb.clears + sb.queries < ITEM_TARGET) begin
      // One phase early on always fills the row and pushes appends past the limit.
      build_row(phase == 2 || $urandom_range(0, 24) == 0);
      repeat ($urandom_range(10, 40)) begin
        case ($urandom_range(0, 19))
          0: send_command(random_fields(CMD_UNUSED));
          1: append_digit(random_digit(), random_scale());
          2: send_command(random_fields(CMD_QUERY));
          default: random_query();
        endcase
      end
      phase++;
    end
  endtask

  // The receiver alternates short ready runs with stalls, and now and then stays ready.
  initial begin
    pixel_chan.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(50, 200)) begin
          @(negedge clk);
          pixel_chan.ready <= 1'b1;
        end
      end else begin
        repeat ($urandom_range(0, 12)) begin
          @(negedge clk);
          pixel_chan.ready <= 1'b1;
        end
        repeat ($urandom_range(1, 20)) begin
          @(negedge clk);
          pixel_chan.ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pixel_chan.valid && pixel_chan.ready)
      sb.check_pixel(pixel_chan.pixel_code, pixel_chan.past_end);
  end

  always @(posedge clk) begin
    if ((cmd_chan.valid && cmd_chan.ready) || (pixel_chan.valid && pixel_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles at %0t", IDLE_LIMIT, $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sb = new();
    burst_left = 0;
    rst = 1'b1;
    cmd_chan.valid        = 1'b0;
    cmd_chan.cmd          = CMD_CLEAR;
    cmd_chan.digit_value  = '0;
    cmd_chan.digit_scale  = '0;
    cmd_chan.query_column = '0;
    cmd_chan.query_row    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random();
    @(negedge clk);
    cmd_chan.valid <= 1'b0;

    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();

    $display("Run covered %0d appends (%0d refused on a full row), %0d clears, %0d queries",
             sb.appends, sb.refused, sb.clears, sb.queries);
    $display("(%0d past the last digit) and %0d unused commands; %0d pixels checked, %0d failures.",
             sb.past_ends, sb.ignored, sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
